[hdl/lbpm_pkg.sv]
// Package for the LRU buffer pool manager core: sizes, request and command codes.
// Depends on nothing; every other file of the block imports it.
package lbpm_pkg;

   localparam int PoolSize = 16;
   localparam int FrameW = $clog2(PoolSize);
   localparam int CountW = $clog2(PoolSize + 1);
   localparam int PinW = 16;
   localparam logic [PinW-1:0] PinMax = '1;
   localparam logic [31:0] NoPage = 32'hFFFF_FFFF;

   localparam logic [2:0] KIND_NEW = 3'd0;
   localparam logic [2:0] KIND_FETCH = 3'd1;
   localparam logic [2:0] KIND_UNPIN = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_FLUSH = 3'd4;
   localparam logic [2:0] KIND_FLUSH_ALL = 3'd5;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_ZERO = 2'd2;
   localparam logic [1:0] OP_REPLY = 2'd3;

   localparam logic [1:0] CSR_INSTANCE_COUNT = 2'd0;
   localparam logic [1:0] CSR_INSTANCE_NUMBER = 2'd1;

   // One request as it arrives.
   typedef struct packed {
      logic [2:0] kind;
      logic signed [31:0] page_id;
      logic mark_dirty;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0] op;
      logic signed [31:0] page_ref;
      logic [3:0] frame;
      logic ok;
      logic last;
   } rsp_type;

   // Commands the sequencer broadcasts to the chain of list cells.
   typedef struct packed {
      logic pop_head;            // remove the head and shift the rest up
      logic remove;              // remove the entry equal to value
      logic push;                // append value at the tail
      logic [FrameW-1:0] value;
   } list_cmd_type;

endpackage

[hdl/lbpm_if.sv]
// Valid/ready channel interface carrying one payload.
// Depends on lbpm_pkg for the payload types.
interface lbpm_req_if;
   import lbpm_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lbpm_rsp_if;
   import lbpm_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/lru_buffer_pool_manager_core.sv]
// Top level of the LRU buffer pool manager: frame table, sequencer and two frame lists.
// Depends on lbpm_pkg, lbpm_if and lbpm_frame_list.
//
//   Channel   Direction   Handshake        Contents
//   req       in          valid/ready      kind, page_id, mark_dirty
//   rsp       out         valid/ready      op, page_ref, frame, ok, last
//   csr       in          write enable     instance_count, instance_number
//
// A request is decided and then issues its commands one after another; flush-all walks
// the frame table, one frame a cycle while no write-back waits on a stalled response.
// Reset is synchronous; the free list is full and the LRU list empty at once.
// A stalled response holds the sequencer; one request is in flight at a time.
module lru_buffer_pool_manager_core (
   input  logic clock,
   input  logic reset,
   lbpm_req_if.sink req,
   lbpm_rsp_if.source rsp,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);
   import lbpm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_DECIDE, S_EVICT, S_CMD, S_WALK, S_REPLY
   } state_type;

   state_type state_ff;
   req_type req_ff;
   logic [4:0] icount_ff;
   logic [31:0] next_page_ff;
   logic [31:0] page_ff [PoolSize];
   logic [PoolSize-1:0] mapped_ff, dirty_ff;
   logic [PinW-1:0] pin_ff [PoolSize];
   logic found_ff;
   logic [FrameW-1:0] frame_ff;
   logic [FrameW-1:0] walk_ff;
   logic rsp_valid_ff;
   logic unpin_ok_ff;
   rsp_type rsp_ff;
   list_cmd_type free_cmd, lru_cmd;
   logic [FrameW-1:0] free_head, lru_head;
   logic free_ne, lru_ne;
   logic [PoolSize-1:0] free_member, lru_member;
   logic hit;
   logic [FrameW-1:0] hit_frame;
   logic [31:0] cmd_page;
   logic [1:0] cmd_op;
   logic rsp_free;

   lbpm_frame_list u_free (
      .clock(clock), .reset(reset), .fill_at_reset(1'b1), .cmd(free_cmd),
      .head(free_head), .not_empty(free_ne), .member(free_member));
   lbpm_frame_list u_lru (
      .clock(clock), .reset(reset), .fill_at_reset(1'b0), .cmd(lru_cmd),
      .head(lru_head), .not_empty(lru_ne), .member(lru_member));

   // Page lookup: lowest resident frame that holds the page.
   always_comb begin
      hit = 1'b0;
      hit_frame = '0;
      for (int i = PoolSize - 1; i >= 0; i--)
         if (mapped_ff[i] && page_ff[i] == req_ff.page_id) begin
            hit = 1'b1;
            hit_frame = FrameW'(i);
         end
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // Sequencer with frame table and output register.
   always_ff @(posedge clock) begin
      free_cmd <= '0;
      lru_cmd <= '0;
      if (reset) begin
         state_ff <= S_IDLE;
         icount_ff <= 5'd1;
         next_page_ff <= '0;
         mapped_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < PoolSize; i++) pin_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_INSTANCE_COUNT: icount_ff <= csr_data;
               CSR_INSTANCE_NUMBER: next_page_ff <= {28'd0, csr_data[3:0]};
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_ff <= req.data;
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               found_ff <= hit;
               frame_ff <= hit_frame;
               walk_ff <= '0;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_REPLY;
               case (req_ff.kind)
                  KIND_NEW, KIND_FETCH: begin
                     if (req_ff.kind == KIND_FETCH && found_ff) begin
                        if (pin_ff[frame_ff] != PinMax)
                           pin_ff[frame_ff] <= pin_ff[frame_ff] + 1'b1;
                        lru_cmd <= '{pop_head: 1'b0, remove: 1'b1, push: 1'b0,
                                     value: frame_ff};
                     end else if (free_ne) begin
                        frame_ff <= free_head;
                        free_cmd <= '{pop_head: 1'b1, remove: 1'b0, push: 1'b0,
                                      value: free_head};
                        found_ff <= 1'b1;
                        state_ff <= S_CMD;
                     end else if (lru_ne) begin
                        frame_ff <= lru_head;
                        lru_cmd <= '{pop_head: 1'b1, remove: 1'b0, push: 1'b0,
                                     value: lru_head};
                        mapped_ff[lru_head] <= 1'b0;
                        found_ff <= 1'b1;
                        state_ff <= dirty_ff[lru_head] ? S_EVICT : S_CMD;
                     end else begin
                        found_ff <= 1'b0;
                        frame_ff <= '0;
                     end
                  end
                  KIND_UNPIN: begin
                     if (found_ff && pin_ff[frame_ff] != '0) begin
                        pin_ff[frame_ff] <= pin_ff[frame_ff] - 1'b1;
                        if (req_ff.mark_dirty) dirty_ff[frame_ff] <= 1'b1;
                        if (pin_ff[frame_ff] == PinW'(1) && !lru_member[frame_ff])
                           lru_cmd <= '{pop_head: 1'b0, remove: 1'b0, push: 1'b1,
                                        value: frame_ff};
                     end
                  end
                  KIND_DELETE: begin
                     if (found_ff && pin_ff[frame_ff] == '0)
                        state_ff <= dirty_ff[frame_ff] ? S_EVICT : S_CMD;
                  end
                  KIND_FLUSH: begin
                     if (found_ff && req_ff.page_id != NoPage) state_ff <= S_EVICT;
                  end
                  KIND_FLUSH_ALL: state_ff <= S_WALK;
                  default: ;
               endcase
            end
            S_EVICT: begin
               // Write-back of the frame before it is reused or zeroed, or for a flush.
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{op: OP_WRITE, page_ref: page_ff[frame_ff],
                              frame: 4'(frame_ff), ok: 1'b0, last: 1'b0};
                  if (req_ff.kind == KIND_FLUSH) begin
                     dirty_ff[frame_ff] <= 1'b0;
                     state_ff <= S_REPLY;
                  end else begin
                     state_ff <= S_CMD;
                  end
               end
            end
            S_CMD: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{op: cmd_op, page_ref: cmd_page, frame: 4'(frame_ff),
                              ok: 1'b0, last: 1'b0};
                  dirty_ff[frame_ff] <= 1'b0;
                  if (req_ff.kind == KIND_DELETE) begin
                     mapped_ff[frame_ff] <= 1'b0;
                     page_ff[frame_ff] <= NoPage;
                     pin_ff[frame_ff] <= '0;
                     lru_cmd <= '{pop_head: 1'b0, remove: 1'b1, push: 1'b0,
                                  value: frame_ff};
                     if (!free_member[frame_ff])
                        free_cmd <= '{pop_head: 1'b0, remove: 1'b0, push: 1'b1,
                                      value: frame_ff};
                  end else begin
                     mapped_ff[frame_ff] <= 1'b1;
                     page_ff[frame_ff] <= cmd_page;
                     pin_ff[frame_ff] <= PinW'(1);
                     if (req_ff.kind == KIND_NEW) begin
                        req_ff.page_id <= cmd_page;
                        next_page_ff <= next_page_ff + {27'd0, icount_ff};
                     end
                  end
                  state_ff <= S_REPLY;
               end
            end
            S_WALK: begin
               if (!mapped_ff[walk_ff] || rsp_free) begin
                  if (mapped_ff[walk_ff]) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= '{op: OP_WRITE, page_ref: page_ff[walk_ff],
                                 frame: 4'(walk_ff), ok: 1'b0, last: 1'b0};
                  end
                  walk_ff <= walk_ff + 1'b1;
                  if (walk_ff == FrameW'(PoolSize - 1)) begin
                     found_ff <= 1'b1;
                     frame_ff <= '0;
                     state_ff <= S_REPLY;
                  end
               end
            end
            S_REPLY: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.op <= OP_REPLY;
                  rsp_ff.last <= 1'b1;
                  rsp_ff.page_ref <= req_ff.page_id;
                  rsp_ff.frame <= 4'(frame_ff);
                  rsp_ff.ok <= 1'b0;
                  case (req_ff.kind)
                     KIND_NEW: begin
                        rsp_ff.ok <= found_ff;
                        if (!found_ff) rsp_ff.page_ref <= NoPage;
                     end
                     KIND_FETCH: rsp_ff.ok <= found_ff;
                     KIND_UNPIN: begin
                        if (!found_ff) rsp_ff.frame <= '0;
                        rsp_ff.ok <= found_ff && unpin_ok_ff;
                     end
                     KIND_DELETE: begin
                        if (!found_ff) rsp_ff.frame <= '0;
                        rsp_ff.ok <= !found_ff || !mapped_ff[frame_ff];
                     end
                     KIND_FLUSH: begin
                        if (!found_ff || req_ff.page_id == NoPage) rsp_ff.frame <= '0;
                        rsp_ff.ok <= found_ff && req_ff.page_id != NoPage;
                     end
                     KIND_FLUSH_ALL: begin
                        rsp_ff.ok <= 1'b1;
                        rsp_ff.page_ref <= NoPage;
                     end
                     default: begin
                        rsp_ff.page_ref <= NoPage;
                        rsp_ff.frame <= '0;
                     end
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Unpin succeeds when the pin count was above zero at decision time.
   always_ff @(posedge clock) begin
      if (state_ff == S_DECIDE) unpin_ok_ff <= (pin_ff[frame_ff] != '0);
   end

   // Command issued in S_CMD: zero for new and delete, read for a fetch miss.
   always_comb begin
      cmd_op = OP_ZERO;
      cmd_page = next_page_ff;
      case (req_ff.kind)
         KIND_FETCH: begin
            cmd_op = OP_READ;
            cmd_page = req_ff.page_id;
         end
         KIND_DELETE: cmd_page = NoPage;
         default: ;
      endcase
   end

   // A frame is never on both lists at once.
   assert property (@(posedge clock) disable iff (reset) (free_member & lru_member) == '0)
      else $error("frame on free and LRU lists");
   // A free frame holds no page.
   assert property (@(posedge clock) disable iff (reset) (free_member & mapped_ff) == '0)
      else $error("free frame still mapped");
   // Only idle state takes a request.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == S_LOOK)
      else $error("request not taken into lookup");
endmodule

[hdl/lbpm_list_cell.sv]
// One cell of an ordered frame list (free FIFO or LRU list).
// Depends on lbpm_pkg; chained by lbpm_frame_list.
module lbpm_list_cell (
   input  logic clock,
   input  logic reset,
   input  logic [lbpm_pkg::FrameW-1:0] reset_value,
   input  logic reset_valid,
   input  lbpm_pkg::list_cmd_type cmd,
   input  logic [lbpm_pkg::FrameW-1:0] next_value,
   input  logic next_valid,
   input  logic prev_valid,
   input  logic shift_in,
   output logic shift_out,
   output logic [lbpm_pkg::FrameW-1:0] value,
   output logic valid
);
   import lbpm_pkg::*;

   logic [FrameW-1:0] value_ff, value_in;
   logic valid_ff, valid_in;
   logic hit;
   logic shift;

   assign hit = valid_ff && (value_ff == cmd.value);
   // A cell takes its neighbour's value once a removal point lies at or above it.
   assign shift = cmd.pop_head || (cmd.remove && (shift_in || hit));
   assign shift_out = cmd.remove && (shift_in || hit);

   // Shift up on removal, fill the first empty cell on a push.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (cmd.push && !valid_ff && prev_valid) begin
         value_in = cmd.value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= reset_value;
         valid_ff <= reset_valid;
      end else begin
         value_ff <= value_in;
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
endmodule

[hdl/lbpm_frame_list.sv]
// Ordered list of frame numbers built as a chain of lbpm_list_cell.
// Depends on lbpm_pkg and lbpm_list_cell.
module lbpm_frame_list (
   input  logic clock,
   input  logic reset,
   input  logic fill_at_reset,
   input  lbpm_pkg::list_cmd_type cmd,
   output logic [lbpm_pkg::FrameW-1:0] head,
   output logic not_empty,
   output logic [lbpm_pkg::PoolSize-1:0] member
);
   import lbpm_pkg::*;

   logic [FrameW-1:0] vals [PoolSize+1];
   logic [PoolSize:0] vlds;
   logic [PoolSize:0] shifts;
   logic [PoolSize-1:0] prevs;
   logic [PoolSize-1:0] mem_bits;

   assign vals[PoolSize] = '0;
   assign vlds[PoolSize] = 1'b0;
   assign shifts[0] = 1'b0;
   // The head cell always sees an occupied cell above it.
   assign prevs = {vlds[PoolSize-2:0], 1'b1};

   for (genvar i = 0; i < PoolSize; i++) begin : g_cell
      lbpm_list_cell u_cell (
         .clock(clock), .reset(reset),
         .reset_value(FrameW'(i)), .reset_valid(fill_at_reset),
         .cmd(cmd),
         .next_value(vals[i+1]), .next_valid(vlds[i+1]),
         .prev_valid(prevs[i]),
         .shift_in(shifts[i]), .shift_out(shifts[i+1]),
         .value(vals[i]), .valid(vlds[i])
      );
   end

   // Membership bitmap: which frames sit in the list.
   always_comb begin
      mem_bits = '0;
      for (int i = 0; i < PoolSize; i++)
         if (vlds[i]) mem_bits[vals[i]] = 1'b1;
   end

   assign head = vals[0];
   assign not_empty = vlds[0];
   assign member = mem_bits;
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LRU buffer pool manager core.
// Depends on lbpm_pkg, the channel interfaces in lbpm_if and the core itself.
module tb_top;
   import lbpm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_INSTANCE_COUNT;
   logic [4:0] csr_data = '0;

   lbpm_req_if req_ch ();
   lbpm_rsp_if rsp_ch ();

   lru_buffer_pool_manager_core dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the pool bookkeeping.
   logic [31:0] frame_page_sh [PoolSize];
   bit frame_used [PoolSize];
   logic [PinW-1:0] pins [PoolSize];
   bit dirty [PoolSize];
   int free_frames [$];
   int lru_frames [$];
   logic [31:0] alloc_page;
   logic [31:0] page_stride;
   rsp_type pending_results [$];

   int errors = 0;
   bit idling = 1'b1;
   int hold_off = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void queue_result(input logic [1:0] op, input logic [31:0] page,
                                        input int frame, input bit ok, input bit last);
      rsp_type r;
      r.op = op;
      r.page_ref = page;
      r.frame = frame[3:0];
      r.ok = ok;
      r.last = last;
      pending_results = {pending_results, r};
   endfunction

   function automatic int lookup_frame(input logic [31:0] page);
      for (int f = 0; f < PoolSize; f++)
         if (frame_used[f] && frame_page_sh[f] == page) return f;
      return -1;
   endfunction

   function automatic void lru_drop(input int frame);
      for (int i = 0; i < lru_frames.size(); i++)
         if (lru_frames[i] == frame) begin
            lru_frames.delete(i);
            return;
         end
   endfunction

   // Free list first, then eviction of the least recently unpinned frame.
   function automatic int claim_frame();
      int f;
      if (free_frames.size() > 0) begin
         f = free_frames[0];
         free_frames.delete(0);
         return f;
      end
      if (lru_frames.size() > 0) begin
         f = lru_frames[0];
         lru_frames.delete(0);
         if (dirty[f]) queue_result(OP_WRITE, frame_page_sh[f], f, 0, 0);
         frame_used[f] = 0;
         return f;
      end
      return -1;
   endfunction

   function automatic void load_frame(input int f, input logic [31:0] page);
      frame_page_sh[f] = page;
      frame_used[f] = 1;
      pins[f] = 1;
      dirty[f] = 0;
   endfunction

   // Works out the commands and reply caused by one accepted request.
   function automatic void predict_pool(input req_type r);
      int f;
      logic [31:0] page;
      page = r.page_id;
      case (r.kind)
         KIND_NEW: begin
            f = claim_frame();
            if (f < 0) queue_result(OP_REPLY, NoPage, 0, 0, 1);
            else begin
               page = alloc_page;
               alloc_page = alloc_page + page_stride;
               load_frame(f, page);
               queue_result(OP_ZERO, page, f, 0, 0);
               queue_result(OP_REPLY, page, f, 1, 1);
            end
         end
         KIND_FETCH: begin
            f = lookup_frame(page);
            if (f >= 0) begin
               if (pins[f] != PinMax) pins[f]++;
               lru_drop(f);
               queue_result(OP_REPLY, page, f, 1, 1);
            end else begin
               f = claim_frame();
               if (f < 0) queue_result(OP_REPLY, page, 0, 0, 1);
               else begin
                  load_frame(f, page);
                  queue_result(OP_READ, page, f, 0, 0);
                  queue_result(OP_REPLY, page, f, 1, 1);
               end
            end
         end
         KIND_UNPIN: begin
            f = lookup_frame(page);
            if (f < 0) queue_result(OP_REPLY, page, 0, 0, 1);
            else if (pins[f] == 0) queue_result(OP_REPLY, page, f, 0, 1);
            else begin
               pins[f]--;
               if (r.mark_dirty) dirty[f] = 1;
               if (pins[f] == 0 && !(f inside {lru_frames})) lru_frames = {lru_frames, f};
               queue_result(OP_REPLY, page, f, 1, 1);
            end
         end
         KIND_DELETE: begin
            f = lookup_frame(page);
            if (f < 0) queue_result(OP_REPLY, page, 0, 1, 1);
            else if (pins[f] > 0) queue_result(OP_REPLY, page, f, 0, 1);
            else begin
               if (dirty[f]) queue_result(OP_WRITE, frame_page_sh[f], f, 0, 0);
               lru_drop(f);
               frame_used[f] = 0;
               frame_page_sh[f] = NoPage;
               dirty[f] = 0;
               queue_result(OP_ZERO, NoPage, f, 0, 0);
               if (free_frames.size() < PoolSize) free_frames = {free_frames, f};
               queue_result(OP_REPLY, page, f, 1, 1);
            end
         end
         KIND_FLUSH: begin
            f = (page == NoPage) ? -1 : lookup_frame(page);
            if (f < 0) queue_result(OP_REPLY, page, 0, 0, 1);
            else begin
               queue_result(OP_WRITE, page, f, 0, 0);
               dirty[f] = 0;
               queue_result(OP_REPLY, page, f, 1, 1);
            end
         end
         KIND_FLUSH_ALL: begin
            for (int u = 0; u < PoolSize; u++)
               if (frame_used[u]) queue_result(OP_WRITE, frame_page_sh[u], u, 0, 0);
            queue_result(OP_REPLY, NoPage, 0, 1, 1);
         end
         default: queue_result(OP_REPLY, NoPage, 0, 0, 1);
      endcase
   endfunction

   // Offers one request, waits for its acceptance and predicts its results.
   task automatic send_request(input logic [2:0] kind, input logic [31:0] page,
                               input bit mark = 0);
      req_type r;
      r.kind = kind;
      r.page_id = page;
      r.mark_dirty = mark;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.data = r;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_pool(r);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Waits until every expected result has arrived and the core has settled.
   task automatic wait_drained();
      while (pending_results.size() > 0) @(negedge clock);
      repeat (PoolSize + 8) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [4:0] value);
      wait_drained();
      csr_index = index;
      csr_data = value;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
      if (index == CSR_INSTANCE_COUNT) page_stride = {27'd0, value};
      else if (index == CSR_INSTANCE_NUMBER) alloc_page = {28'd0, value[3:0]};
   endtask

   // Picks a page that is mostly resident, otherwise small, random or invalid.
   function automatic logic [31:0] pick_page();
      int used [$];
      for (int f = 0; f < PoolSize; f++) if (frame_used[f]) used = {used, f};
      if (used.size() > 0 && $urandom_range(0, 9) < 8)
         return frame_page_sh[used[$urandom_range(0, used.size() - 1)]];
      case ($urandom_range(0, 3))
         0: return NoPage;
         1: return $urandom;
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // Receiver readiness: random short stalls, plus long hold-offs on request.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready = 1'b0;
      else if (hold_off > 0) begin
         rsp_ch.ready = 1'b0;
         hold_off--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready = 1'b0;
         hold_off = $urandom_range(0, 2);
      end else rsp_ch.ready = 1'b1;
   end

   // Compares every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (pending_results.size() == 0)
            report_mismatch($sformatf("unexpected result op %0d page %0d", got.op, got.page_ref));
         else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (got.op !== want.op)
               report_mismatch($sformatf("op %0d, expected %0d", got.op, want.op));
            if (got.page_ref !== want.page_ref)
               report_mismatch($sformatf("page_ref %0d, expected %0d",
                                         got.page_ref, want.page_ref));
            if (got.frame !== want.frame)
               report_mismatch($sformatf("frame %0d, expected %0d", got.frame, want.frame));
            if (got.ok !== want.ok)
               report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
         end
      end
   end

   // Every request kind and the corner cases of each.
   task automatic test_directed();
      send_request(KIND_NEW, 0);
      send_request(KIND_NEW, 0);
      send_request(KIND_FETCH, 0);
      send_request(KIND_UNPIN, 0, 1);
      send_request(KIND_UNPIN, 0, 0);
      send_request(KIND_UNPIN, 0, 1);
      send_request(KIND_FLUSH, 0);
      send_request(KIND_FLUSH, NoPage);
      send_request(KIND_FLUSH, 999);
      send_request(KIND_DELETE, 1);
      send_request(KIND_UNPIN, 1, 1);
      send_request(KIND_DELETE, 1);
      send_request(KIND_DELETE, 555);
      send_request(KIND_UNPIN, 777);
      send_request(KIND_FETCH, NoPage);
      send_request(KIND_FETCH, 32'h7FFF_FFFF);
      send_request(KIND_UNPIN, NoPage, 1);
      send_request(KIND_FLUSH_ALL, 0);
      send_request(3'd6, 32'h1234_5678, 1);
      send_request(3'd7, 0);
   endtask

   // Fills the pool, checks failures, then releases pins so eviction happens.
   task automatic test_pool_exhaustion();
      repeat (PoolSize + 2) send_request(KIND_NEW, 0);
      send_request(KIND_FETCH, 12345);
      for (int f = 0; f < PoolSize; f++)
         while (frame_used[f] && pins[f] > 0)
            send_request(KIND_UNPIN, frame_page_sh[f], 1'($urandom_range(0, 1)));
      repeat (4) send_request(KIND_NEW, 0);
      send_request(KIND_FETCH, 12345);
   endtask

   // Register settings, including a stride of zero and a duplicated page id.
   task automatic test_registers();
      write_register(CSR_INSTANCE_NUMBER, 5'd5);
      send_request(KIND_FETCH, 5);
      send_request(KIND_NEW, 0);
      send_request(KIND_FETCH, 5);
      write_register(CSR_INSTANCE_COUNT, 5'd0);
      repeat (2) send_request(KIND_NEW, 0);
      write_register(CSR_INSTANCE_COUNT, 5'd16);
      write_register(CSR_INSTANCE_NUMBER, 5'd15);
      repeat (2) send_request(KIND_NEW, 0);
      write_register(CSR_INSTANCE_COUNT, 5'd31);
      write_register(CSR_INSTANCE_NUMBER, 5'd0);
      repeat (2) send_request(KIND_NEW, 0);
      send_request(KIND_FLUSH_ALL, 0);
      write_register(CSR_INSTANCE_COUNT, 5'd1);
   endtask

   // Mixed traffic weighted towards pages that are resident.
   task automatic test_random_traffic(input int count);
      int w;
      for (int i = 0; i < count; i++) begin
         w = $urandom_range(0, 99);
         if (w < 18) send_request(KIND_NEW, $urandom);
         else if (w < 48) send_request(KIND_FETCH, pick_page());
         else if (w < 73)
            send_request(KIND_UNPIN, pick_page(), 1'($urandom_range(0, 1)));
         else if (w < 84) send_request(KIND_DELETE, pick_page());
         else if (w < 94)
            send_request(KIND_FLUSH, pick_page(), 1'($urandom_range(0, 1)));
         else if (w < 98) send_request(KIND_FLUSH_ALL, $urandom);
         else send_request(3'($urandom_range(6, 7)), $urandom, 1'($urandom_range(0, 1)));
         if (i % 50 == 25) begin
            write_register(CSR_INSTANCE_COUNT, 5'($urandom_range(1, 16)));
            write_register(CSR_INSTANCE_NUMBER, 5'($urandom_range(0, 15)));
         end
      end
   endtask

   // The receiver holds off so the core fills up and stalls its input.
   task automatic test_back_pressure();
      wait_drained();
      hold_off = 300;
      repeat (12) send_request(KIND_FETCH, pick_page());
      send_request(KIND_FLUSH_ALL, 0);
      wait_drained();
      repeat (6) send_request(KIND_UNPIN, pick_page(), 1);
   endtask

   // Repeated fetches stack pins on one page; unpins release them and the extra one fails.
   task automatic test_repeated_fetch();
      repeat (4) send_request(KIND_FETCH, 4242);
      repeat (5) send_request(KIND_UNPIN, 4242);
   endtask

   initial begin
      for (int f = 0; f < PoolSize; f++) begin
         frame_used[f] = 0;
         pins[f] = 0;
         dirty[f] = 0;
         frame_page_sh[f] = '0;
         free_frames = {free_frames, f};
      end
      page_stride = 1;
      alloc_page = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_pool_exhaustion();
      test_registers();
      test_random_traffic(100);
      test_back_pressure();
      idling = 1'b0;
      test_repeated_fetch();
      test_random_traffic(30);
      while (pending_results.size() > 0) @(negedge clock);
      repeat (PoolSize + 8) @(negedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Hard limit well beyond the slowest correct run.
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
hdl/lbpm_pkg.sv
hdl/lbpm_if.sv
hdl/lbpm_list_cell.sv
hdl/lbpm_frame_list.sv
hdl/lru_buffer_pool_manager_core.sv
verif/tb_top.sv
